[hw/rtl/nsdr_pkg.sv]
// Package for the suspect-router detect/reroute block: beat structs,
// direction and register codes, detour tables and the divide step.
// No dependencies.
`timescale 1ns / 1ps

package nsdr_pkg;

    localparam int COLS_W           = 5;
    localparam int MAX_MESH_COLS    = 16;
    localparam int ID_W             = 8;
    localparam int DIR_W            = 3;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 8;

    typedef logic [DIR_W-1:0] t_dir;

    localparam t_dir DIR_LOCAL = 3'd0;
    localparam t_dir DIR_NORTH = 3'd1;
    localparam t_dir DIR_EAST  = 3'd2;
    localparam t_dir DIR_SOUTH = 3'd3;
    localparam t_dir DIR_WEST  = 3'd4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_CAGING_ON        = 3'd0;
    localparam t_cfg_idx CFG_ALERT_GENERATOR  = 3'd1;
    localparam t_cfg_idx CFG_ALERT_PROPAGATOR = 3'd2;
    localparam t_cfg_idx CFG_ALERT_DIRECTION  = 3'd3;
    localparam t_cfg_idx CFG_ROUTER_ID        = 3'd4;
    localparam t_cfg_idx CFG_MESH_COLS        = 3'd5;
    localparam t_cfg_idx CFG_DETECT_THRESHOLD = 3'd6;
    localparam t_cfg_idx CFG_SUSPECT_ID       = 3'd7;

    localparam logic [COLS_W-1:0] MESH_COLS_RST = 5'd8;
    localparam logic [ID_W-1:0]   THRESH_RST    = 8'd8;
    localparam logic [ID_W-1:0]   SUSPECT_RST   = 8'd28;

    typedef struct packed {
        logic [ID_W-1:0] dest_id;
        t_dir            arrival_dir;
        t_dir            routed_dir;
        logic            marked_modified;
        logic [ID_W-1:0] last_router;
        logic            already_rerouted;
    } t_in_beat;

    typedef struct packed {
        t_dir            final_dir;
        logic            rerouted_mark;
        logic            newly_rerouted;
        logic            alert_raised;
        logic [ID_W-1:0] alert_target;
    } t_out_beat;

    // Signs of the x/y offsets to the destination
    typedef struct packed {
        logic dx_pos;
        logic dx_neg;
        logic dy_pos;
        logic dy_neg;
    } t_offs;

    // One restoring-division step: {new remainder, quotient bit}
    function automatic logic [COLS_W:0] div_step(input logic [COLS_W-1:0] rem,
                                                 input logic              dbit,
                                                 input logic [COLS_W-1:0] cols);
        logic [COLS_W-1:0] t;
        t = {rem[COLS_W-2:0], dbit};
        if (t >= cols) begin
            return {t - cols, 1'b1};
        end
        return {t, 1'b0};
    endfunction

    function automatic t_dir ns_by_y(input t_offs o);
        return o.dy_neg ? DIR_SOUTH : DIR_NORTH;
    endfunction

    function automatic t_dir gen_horiz(input t_dir out, input t_dir in_d, input t_dir ad,
                                       input t_dir toward, input t_dir back,
                                       input t_offs o);
        if (in_d == toward) return ns_by_y(o);
        if (ad != toward) return toward;
        if (in_d == back || in_d == DIR_LOCAL) return ns_by_y(o);
        if (in_d == DIR_NORTH) return DIR_SOUTH;
        if (in_d == DIR_SOUTH) return DIR_NORTH;
        return out;
    endfunction

    function automatic t_dir gen_table(input t_dir out, input t_dir in_d, input t_dir ad,
                                       input t_offs o);
        t_dir r;
        r = out;
        if (o.dx_pos) return gen_horiz(out, in_d, ad, DIR_EAST, DIR_WEST, o);
        if (o.dx_neg) return gen_horiz(out, in_d, ad, DIR_WEST, DIR_EAST, o);
        if (in_d == DIR_LOCAL) begin
            if (!o.dy_neg && ad != DIR_NORTH)      r = DIR_NORTH;
            else if (!o.dy_pos && ad != DIR_SOUTH) r = DIR_SOUTH;
            else if (!o.dy_neg)                    r = DIR_EAST;
            else                                   r = DIR_WEST;
        end
        if (o.dy_pos && ad != DIR_NORTH)      r = (in_d != DIR_NORTH) ? DIR_NORTH : DIR_EAST;
        else if (o.dy_pos)                    r = (in_d != DIR_WEST)  ? DIR_WEST  : DIR_EAST;
        else if (o.dy_neg && ad != DIR_SOUTH) r = (in_d != DIR_SOUTH) ? DIR_SOUTH : DIR_WEST;
        else if (o.dy_neg)                    r = (in_d != DIR_WEST)  ? DIR_WEST  : DIR_EAST;
        return r;
    endfunction

    function automatic t_dir prop_table(input t_dir in_d, input t_offs o);
        if (o.dx_pos) return (in_d != DIR_EAST) ? DIR_EAST : ns_by_y(o);
        if (o.dx_neg) return (in_d != DIR_WEST) ? DIR_WEST : ns_by_y(o);
        if (!o.dy_neg) return (in_d != DIR_NORTH) ? DIR_NORTH : DIR_WEST;
        return (in_d != DIR_SOUTH) ? DIR_SOUTH : DIR_EAST;
    endfunction

endpackage

[hw/rtl/noc_suspect_detect_reroute.sv]
// Suspect-router detection and detour selection for one head flit.
// Depends on nsdr_pkg (beat structs, codes, detour tables, divide step).
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one head-flit
//   beat. Output channel (o_out_valid / i_out_stall / o_out_data) returns
//   one result beat per input beat, in order.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
//   writes one register per beat; write only while the block is idle.
// Timing:
//   Detection (counter, alert) is settled at the input beat. The mesh x/y
//   coordinates of destination and this router come from two
//   divide-by-columns steps that share one column count, one quotient bit
//   per cycle for both ids; the divide states are followed by a decision
//   state that loads the result register, and a new beat is taken the cycle
//   after that, so an item is done before the next one is taken.
//   The result register parts the two sides: a stalled output holds its
//   beat, the next item still runs and waits in the decision cycle until
//   the register frees up.
// Reset: registers return to their listed values, counter and rerouting
//   flag clear, no result is pending.
module noc_suspect_detect_reroute #(
    parameter int P_MAX_COLS = nsdr_pkg::MAX_MESH_COLS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  nsdr_pkg::t_in_beat            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output nsdr_pkg::t_out_beat           o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  nsdr_pkg::t_cfg_idx            i_cfg_index,
    input  logic [nsdr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = nsdr_pkg::COLS_W;
    localparam int IW = nsdr_pkg::ID_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    // config registers
    logic                 r_caging, r_gen, r_prop;
    nsdr_pkg::t_dir       r_alert_dir;
    logic [IW-1:0]        r_router_id, r_thresh, r_suspect;
    logic [CW-1:0]        r_mesh_cols;

    t_state               r_state, n_state;
    logic [2:0]           r_step, n_step;
    logic [IW-1:0]        r_count, n_count;
    logic                 r_active, n_active;
    logic                 r_alert, n_alert;
    nsdr_pkg::t_in_beat   r_in, n_in;
    logic [CW-1:0]        r_cols, n_cols;
    logic [IW-1:0]        r_dq, n_dq, r_rq, n_rq;
    logic [CW-1:0]        r_drem, n_drem, r_rrem, n_rrem;
    logic                 r_out_vld, n_out_vld;
    nsdr_pkg::t_out_beat  r_out, n_out;

    logic                 in_acc, out_free;
    logic [CW:0]          d_step, rid_step;
    logic [IW-1:0]        cnt_inc;
    nsdr_pkg::t_offs      offs;
    nsdr_pkg::t_dir       nd;
    logic                 reroute;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caging    <= 1'b0;
            r_gen       <= 1'b0;
            r_prop      <= 1'b0;
            r_alert_dir <= nsdr_pkg::DIR_LOCAL;
            r_router_id <= '0;
            r_mesh_cols <= nsdr_pkg::MESH_COLS_RST;
            r_thresh    <= nsdr_pkg::THRESH_RST;
            r_suspect   <= nsdr_pkg::SUSPECT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                nsdr_pkg::CFG_CAGING_ON:        r_caging    <= i_cfg_data[0];
                nsdr_pkg::CFG_ALERT_GENERATOR:  r_gen       <= i_cfg_data[0];
                nsdr_pkg::CFG_ALERT_PROPAGATOR: r_prop      <= i_cfg_data[0];
                nsdr_pkg::CFG_ALERT_DIRECTION:  r_alert_dir <= i_cfg_data[2:0];
                nsdr_pkg::CFG_ROUTER_ID:        r_router_id <= i_cfg_data;
                nsdr_pkg::CFG_MESH_COLS:        r_mesh_cols <= i_cfg_data[CW-1:0];
                nsdr_pkg::CFG_DETECT_THRESHOLD: r_thresh    <= i_cfg_data;
                nsdr_pkg::CFG_SUSPECT_ID:       r_suspect   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // divide steps, one per id, sharing r_cols: one step per cycle on both ids
    assign d_step   = nsdr_pkg::div_step(r_drem, r_dq[IW-1], r_cols);
    assign rid_step = nsdr_pkg::div_step(r_rrem, r_rq[IW-1], r_cols);

    assign cnt_inc = r_count + IW'(i_in_data.marked_modified &&
                                   (i_in_data.last_router == r_suspect));

    // offsets: x from remainders, y from quotients
    always_comb begin
        offs.dx_pos = r_drem > r_rrem;
        offs.dx_neg = r_drem < r_rrem;
        offs.dy_pos = r_dq > r_rq;
        offs.dy_neg = r_dq < r_rq;
    end

    always_comb begin
        reroute = (r_in.dest_id != r_suspect) && (r_caging || r_active ||
                  r_in.already_rerouted);
        case (r_in.routed_dir) inside
            [nsdr_pkg::DIR_NORTH:nsdr_pkg::DIR_WEST]: ;
            default: reroute = 1'b0;
        endcase
        nd = r_in.routed_dir;
        if (r_gen && (r_in.routed_dir == r_alert_dir)) begin
            nd = nsdr_pkg::gen_table(r_in.routed_dir, r_in.arrival_dir, r_alert_dir, offs);
        end else if (r_prop) begin
            nd = nsdr_pkg::prop_table(r_in.arrival_dir, offs);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_count   = r_count;
        n_active  = r_active;
        n_alert   = r_alert;
        n_in      = r_in;
        n_cols    = r_cols;
        n_dq      = r_dq;
        n_rq      = r_rq;
        n_drem    = r_drem;
        n_rrem    = r_rrem;
        n_out_vld = r_out_vld && i_out_stall;
        n_out     = r_out;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_in    = i_in_data;
                    n_alert = 1'b0;
                    if (!r_active) begin
                        if (cnt_inc >= r_thresh) begin
                            n_alert  = 1'b1;
                            n_active = 1'b1;
                            n_count  = '0;
                        end else begin
                            n_count = cnt_inc;
                        end
                    end
                    if (r_mesh_cols < CW'(2)) begin
                        n_cols = CW'(2);
                    end else if (r_mesh_cols > CW'(P_MAX_COLS)) begin
                        n_cols = CW'(P_MAX_COLS);
                    end else begin
                        n_cols = r_mesh_cols;
                    end
                    n_dq    = i_in_data.dest_id;
                    n_rq    = r_router_id;
                    n_drem  = '0;
                    n_rrem  = '0;
                    n_step  = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_drem = d_step[CW:1];
                n_dq   = {r_dq[IW-2:0], d_step[0]};
                n_rrem = rid_step[CW:1];
                n_rq   = {r_rq[IW-2:0], rid_step[0]};
                n_step = r_step + 3'd1;
                if (r_step == 3'd7) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out.final_dir      = reroute ? nd : r_in.routed_dir;
                    n_out.rerouted_mark  = r_in.already_rerouted ||
                                           (reroute && (nd != r_in.routed_dir));
                    n_out.newly_rerouted = !r_in.already_rerouted &&
                                           reroute && (nd != r_in.routed_dir);
                    n_out.alert_raised   = r_alert;
                    n_out.alert_target   = r_alert ? r_in.last_router : '0;
                    n_out_vld            = 1'b1;
                    n_state              = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= '0;
            r_count   <= '0;
            r_active  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_count   <= n_count;
            r_active  <= n_active;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_alert <= n_alert;
        r_in    <= n_in;
        r_cols  <= n_cols;
        r_dq    <= n_dq;
        r_rq    <= n_rq;
        r_drem  <= n_drem;
        r_rrem  <= n_rrem;
        r_out   <= n_out;
    end

    // counter stays clear once rerouting is on
    a_cnt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_count == '0))
        else $error("suspicious count nonzero while rerouting");

    a_tgt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.alert_raised) |-> (o_out_data.alert_target == '0))
        else $error("alert target without alert");

    a_newly_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.newly_rerouted) |-> o_out_data.rerouted_mark)
        else $error("newly rerouted without mark");

    // an alert can only come with the flag being set
    a_alert_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && r_alert) |-> r_active)
        else $error("alert raised but rerouting off");

endmodule
